// ----- hdl/assert_macros.svh -----
// Assertion macros used by the timer scheduler datapath (tes_dp).
// Uses the clk and rst_n names of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/tes_pkg.sv -----
// Package for the timer expiry scheduler: codes, widths and command/status types.
// No dependencies; used by every module of the block except tes_ram.
`default_nettype none

package tes_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_FIRES   = 16;
  localparam int FIRE_CW     = $clog2(MAX_FIRES + 1);
  localparam int TPS_W       = 20;
  localparam int SEC_W       = 32;
  localparam int TICK_W      = 64;
  localparam int PROD_W      = SEC_W + TPS_W;
  localparam int REP_W       = 16;
  localparam int FC_W        = 17;
  localparam int OSLOT_W     = 4;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);
  localparam logic signed [FC_W-1:0] FC_FOREVER = -17'sd1;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ARGS = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef logic [2:0] em_sel_t;
  localparam em_sel_t EM_ADD_BAD  = 3'd0;
  localparam em_sel_t EM_ADD_FULL = 3'd1;
  localparam em_sel_t EM_ADD_OK   = 3'd2;
  localparam em_sel_t EM_CANCEL   = 3'd3;
  localparam em_sel_t EM_PEND     = 3'd4;
  localparam em_sel_t EM_FINAL    = 3'd5;

  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_step;
    logic    scan_rd;
    logic    add_take;
    logic    mul_first;
    logic    mul_reload;
    logic    wr_exp_add;
    logic    wr_rest_add;
    logic    run_init;
    logic    pass_init;
    logic    fire;
    logic    emit;
    em_sel_t emit_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       add_bad;
    logic       scan_free;
    logic       scan_end;
    logic       have_best;
    logic       pend_vld;
    logic       last_fire;
    logic       out_free;
  } dp_status_t;

  function automatic logic [TICK_W-1:0] sat_add64(input logic [TICK_W-1:0] a,
                                                  input logic [TICK_W-1:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_W] ? {TICK_W{1'b1}} : s[TICK_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/timer_expiry_scheduler_core.sv -----
// Cancel: decode, then reply. Add: decode, serial free-slot scan, then the first-delay and reload multiplies.
// Run: repeated scan passes over the table for due timers, up to 16 firings, plus a closing
// pass unless 16 fired; results trail their firing by a pass.
// One item at a time; a new item is taken while the last result still waits.
// Reset: synchronous active low; table empty, ticks_per_second 1000, no clearing pass.
// Top level: APB register, controller and datapath. Depends on tes_pkg, tes_ctrl, tes_dp.
`default_nettype none

module timer_expiry_scheduler_core #(
  parameter int SLOTS = tes_pkg::SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_mode,
  input  wire logic [tes_pkg::TICK_W-1:0]       in_now_tick,
  input  wire logic [tes_pkg::SEC_W-1:0]        in_first_delay_sec,
  input  wire logic [tes_pkg::SEC_W-1:0]        in_reload_sec,
  input  wire logic signed [tes_pkg::FC_W-1:0]  in_fire_count,
  input  wire logic [3:0]                       in_target_slot,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_kind,
  output logic [1:0]                            out_status,
  output logic [tes_pkg::OSLOT_W-1:0]           out_slot,
  output logic                                  out_nothing_due,
  output logic                                  out_last,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [2:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  import tes_pkg::*;

  logic [TPS_W-1:0] tps_r;
  ctrl_cmd_t        cmd;
  dp_status_t       st;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - TPS_W){1'b0}}, tps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      tps_r <= pwdata[TPS_W-1:0];
    end
  end

  tes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tes_dp #(.SLOTS(SLOTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_mode            (in_mode),
    .in_now_tick        (in_now_tick),
    .in_first_delay_sec (in_first_delay_sec),
    .in_reload_sec      (in_reload_sec),
    .in_fire_count      (in_fire_count),
    .in_target_slot     (in_target_slot),
    .tps                (tps_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_nothing_due    (out_nothing_due),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// ----- hdl/tes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/tes_ctrl.sv -----
// Controller state machine of the timer scheduler: sequences add, cancel and run.
// Depends on tes_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module tes_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tes_pkg::dp_status_t st,
  output tes_pkg::ctrl_cmd_t       cmd
);

  import tes_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_FSCAN   = 4'd2;
  localparam logic [3:0] S_MUL_A   = 4'd3;
  localparam logic [3:0] S_MUL_B   = 4'd4;
  localparam logic [3:0] S_MUL_C   = 4'd5;
  localparam logic [3:0] S_REPLY   = 4'd6;
  localparam logic [3:0] S_RSCAN   = 4'd7;
  localparam logic [3:0] S_RDRAIN  = 4'd8;
  localparam logic [3:0] S_RDECIDE = 4'd9;
  localparam logic [3:0] S_RPEND   = 4'd10;
  localparam logic [3:0] S_FIRE    = 4'd11;
  localparam logic [3:0] S_RFINAL  = 4'd12;

  logic [3:0] state_r, state_nxt;
  em_sel_t    em_sel_r, em_sel_nxt;

  always_comb begin
    state_nxt  = state_r;
    em_sel_nxt = em_sel_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.mode)
          MODE_ADD: begin
            if (st.add_bad) begin
              em_sel_nxt = EM_ADD_BAD;
              state_nxt  = S_REPLY;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_FSCAN;
            end
          end
          MODE_CANCEL: begin
            em_sel_nxt = EM_CANCEL;
            state_nxt  = S_REPLY;
          end
          MODE_RUN: begin
            cmd.run_init  = 1'b1;
            cmd.pass_init = 1'b1;
            cmd.scan_clr  = 1'b1;
            state_nxt     = S_RSCAN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FSCAN: begin
        if (st.scan_free) begin
          cmd.add_take  = 1'b1;
          state_nxt     = S_MUL_A;
        end else if (st.scan_end) begin
          em_sel_nxt = EM_ADD_FULL;
          state_nxt  = S_REPLY;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MUL_A: begin
        cmd.mul_first = 1'b1;
        state_nxt     = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.wr_exp_add = 1'b1;
        cmd.mul_reload = 1'b1;
        state_nxt      = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.wr_rest_add = 1'b1;
        em_sel_nxt      = EM_ADD_OK;
        state_nxt       = S_REPLY;
      end
      S_REPLY: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = em_sel_r;
          state_nxt    = S_IDLE;
        end
      end
      S_RSCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_end) begin
          state_nxt = S_RDRAIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RDRAIN: state_nxt = S_RDECIDE;
      S_RDECIDE: begin
        if (!st.have_best) begin
          state_nxt = S_RFINAL;
        end else if (st.pend_vld) begin
          state_nxt = S_RPEND;
        end else begin
          state_nxt = S_FIRE;
        end
      end
      S_RPEND: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_PEND;
          state_nxt    = S_FIRE;
        end
      end
      S_FIRE: begin
        cmd.fire = 1'b1;
        if (st.last_fire) begin
          state_nxt = S_RFINAL;
        end else begin
          cmd.pass_init = 1'b1;
          cmd.scan_clr  = 1'b1;
          state_nxt     = S_RSCAN;
        end
      end
      S_RFINAL: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_FINAL;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      em_sel_r <= EM_ADD_BAD;
    end else begin
      state_r  <= state_nxt;
      em_sel_r <= em_sel_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tes_dp.sv -----
// Datapath of the timer scheduler: timer tables, slot scan, earliest-expiry
// compare, interval multiplier and result register. Depends on tes_pkg, tes_ram.
`default_nettype none
`include "assert_macros.svh"

module tes_dp #(
  parameter int SLOTS = tes_pkg::SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tes_pkg::ctrl_cmd_t               cmd,
  output tes_pkg::dp_status_t                   st,
  input  wire logic [1:0]                       in_mode,
  input  wire logic [tes_pkg::TICK_W-1:0]       in_now_tick,
  input  wire logic [tes_pkg::SEC_W-1:0]        in_first_delay_sec,
  input  wire logic [tes_pkg::SEC_W-1:0]        in_reload_sec,
  input  wire logic signed [tes_pkg::FC_W-1:0]  in_fire_count,
  input  wire logic [3:0]                       in_target_slot,
  input  wire logic [tes_pkg::TPS_W-1:0]        tps,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_kind,
  output logic [1:0]                            out_status,
  output logic [tes_pkg::OSLOT_W-1:0]           out_slot,
  output logic                                  out_nothing_due,
  output logic                                  out_last
);

  import tes_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  localparam int REPRW = REP_W + 1;

  // latched item
  logic [1:0]              mode_r;
  logic [TICK_W-1:0]       now_r;
  logic [SEC_W-1:0]        first_r;
  logic [SEC_W-1:0]        reload_r;
  logic signed [FC_W-1:0]  fc_r;
  logic [3:0]              target_r;

  logic [SLOTS-1:0]        used_r;
  logic [SLOTS-1:0]        fired_r;
  logic [SW-1:0]           scan_r;
  logic [SW-1:0]           slot_r;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W-1:0]       prod_nxt;

  logic                    cmp_vld_r;
  logic [SW-1:0]           cmp_idx_r;
  logic                    have_best_r;
  logic [SW-1:0]           best_idx_r;
  logic [TICK_W-1:0]       best_exp_r;
  logic [TICK_W-1:0]       best_rel_r;
  logic [REPRW-1:0]        best_rep_r;
  logic                    pend_vld_r;
  logic [SW-1:0]           pend_slot_r;
  logic [FIRE_CW-1:0]      n_r;

  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic [1:0]              out_status_r;
  logic [OSLOT_W-1:0]      out_slot_r;
  logic                    out_nd_r;
  logic                    out_last_r;

  logic                    fc_forever;
  logic                    add_bad;
  logic                    cancel_ok;
  logic [SW-1:0]           tgt_idx;
  logic                    out_free;
  logic                    better;
  logic [REP_W-1:0]        rep_new;
  logic                    rearm;
  logic [TICK_W-1:0]       rearm_tick;

  logic                    exp_we;
  logic [SW-1:0]           exp_waddr;
  logic [TICK_W-1:0]       exp_wdata;
  logic [TICK_W-1:0]       exp_q;
  logic [TICK_W-1:0]       rel_q;
  logic                    rep_we;
  logic [REPRW-1:0]        rep_wdata;
  logic [REPRW-1:0]        rep_q;

  logic [1:0]              em_kind;
  logic [1:0]              em_status;
  logic [OSLOT_W-1:0]      em_slot;
  logic                    em_nd;
  logic                    em_last;

  assign fc_forever = (fc_r == FC_FOREVER);
  assign add_bad    = !(fc_forever || (fc_r > 17'sd0)) ||
                      (fc_forever && (reload_r == '0));
  assign tgt_idx    = SW'(target_r);
  assign cancel_ok  = ({28'd0, target_r} < 32'(SLOTS)) && used_r[tgt_idx];
  assign out_free   = !out_valid_r || out_ready;

  assign prod_nxt   = PROD_W'(cmd.mul_reload ? reload_r : first_r) * PROD_W'(tps);

  assign better = cmp_vld_r && used_r[cmp_idx_r] && !fired_r[cmp_idx_r] &&
                  (exp_q <= now_r) && (!have_best_r || (exp_q < best_exp_r));

  assign rep_new    = (!best_rep_r[REP_W] && (best_rep_r[REP_W-1:0] != '0)) ?
                      best_rep_r[REP_W-1:0] - REP_W'(1) : best_rep_r[REP_W-1:0];
  assign rearm      = best_rep_r[REP_W] || (rep_new != '0);
  assign rearm_tick = sat_add64(now_r, best_rel_r);

  assign exp_we    = cmd.wr_exp_add || cmd.fire;
  assign exp_waddr = cmd.fire ? best_idx_r : slot_r;
  assign exp_wdata = cmd.fire ? rearm_tick : sat_add64(now_r, TICK_W'(prod_r));
  assign rep_we    = cmd.wr_rest_add || cmd.fire;
  assign rep_wdata = cmd.fire ? {best_rep_r[REP_W], rep_new} :
                     {fc_forever, fc_forever ? {REP_W{1'b0}} : fc_r[REP_W-1:0]};

  tes_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .raddr (scan_r),
    .rdata (exp_q)
  );

  tes_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_rel_ram (
    .clk   (clk),
    .we    (cmd.wr_rest_add),
    .waddr (slot_r),
    .wdata (TICK_W'(prod_r)),
    .raddr (scan_r),
    .rdata (rel_q)
  );

  tes_ram #(.WIDTH(REPRW), .DEPTH(SLOTS)) u_rep_ram (
    .clk   (clk),
    .we    (rep_we),
    .waddr (exp_waddr),
    .wdata (rep_wdata),
    .raddr (scan_r),
    .rdata (rep_q)
  );

  always_comb begin
    em_kind   = KIND_FIRED;
    em_status = ST_OK;
    em_slot   = '0;
    em_nd     = 1'b0;
    em_last   = 1'b1;
    unique case (cmd.emit_sel)
      EM_ADD_BAD: begin
        em_kind   = KIND_ADD;
        em_status = ST_BAD_ARGS;
      end
      EM_ADD_FULL: begin
        em_kind   = KIND_ADD;
        em_status = ST_FULL;
      end
      EM_ADD_OK: begin
        em_kind = KIND_ADD;
        em_slot = OSLOT_W'(slot_r);
      end
      EM_CANCEL: begin
        em_kind   = KIND_CANCEL;
        em_status = cancel_ok ? ST_OK : ST_EMPTY;
        em_slot   = target_r;
      end
      EM_PEND: begin
        em_slot = OSLOT_W'(pend_slot_r);
        em_last = 1'b0;
      end
      EM_FINAL: begin
        em_slot = pend_vld_r ? OSLOT_W'(pend_slot_r) : '0;
        em_nd   = !pend_vld_r;
      end
      default: em_kind = KIND_FIRED;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      now_r    <= in_now_tick;
      first_r  <= in_first_delay_sec;
      reload_r <= in_reload_sec;
      fc_r     <= in_fire_count;
      target_r <= in_target_slot;
    end
    if (cmd.add_take) begin
      slot_r <= scan_r;
    end
    if (cmd.mul_first || cmd.mul_reload) begin
      prod_r <= prod_nxt;
    end
    cmp_idx_r <= scan_r;
    if (better) begin
      best_idx_r <= cmp_idx_r;
      best_exp_r <= exp_q;
      best_rel_r <= rel_q;
      best_rep_r <= rep_q;
    end
    if (cmd.fire) begin
      pend_slot_r <= best_idx_r;
    end
    if (cmd.emit) begin
      out_kind_r   <= em_kind;
      out_status_r <= em_status;
      out_slot_r   <= em_slot;
      out_nd_r     <= em_nd;
      out_last_r   <= em_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      fired_r     <= '0;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      have_best_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.scan_clr) begin
        scan_r <= '0;
      end else if (cmd.scan_step) begin
        scan_r <= scan_r + SW'(1);
      end
      if (cmd.wr_rest_add) begin
        used_r[slot_r] <= 1'b1;
      end
      if (cmd.emit && (cmd.emit_sel == EM_CANCEL) && cancel_ok) begin
        used_r[tgt_idx] <= 1'b0;
      end
      if (cmd.run_init) begin
        fired_r    <= '0;
        pend_vld_r <= 1'b0;
        n_r        <= '0;
      end
      if (cmd.pass_init) begin
        have_best_r <= 1'b0;
      end else if (better) begin
        have_best_r <= 1'b1;
      end
      if (cmd.fire) begin
        fired_r[best_idx_r] <= 1'b1;
        pend_vld_r          <= 1'b1;
        n_r                 <= n_r + FIRE_CW'(1);
        if (!rearm) begin
          used_r[best_idx_r] <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.mode      = mode_r;
  assign st.add_bad   = add_bad;
  assign st.scan_free = !used_r[scan_r];
  assign st.scan_end  = (scan_r == SW'(SLOTS - 1));
  assign st.have_best = have_best_r;
  assign st.pend_vld  = pend_vld_r;
  assign st.last_fire = (n_r == FIRE_CW'(MAX_FIRES - 1));
  assign st.out_free  = out_free;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_nothing_due = out_nd_r;
  assign out_last        = out_last_r;

  `ASSERT_IMPL(a_emit_free, cmd.emit, out_free)
  `ASSERT_IMPL(a_fire_best, cmd.fire, have_best_r && !fired_r[best_idx_r])
  `ASSERT_IMPL(a_take_free, cmd.wr_rest_add, !used_r[slot_r])
  `ASSERT_NEXT(a_fire_cap, cmd.fire, n_r <= FIRE_CW'(MAX_FIRES))

endmodule

`default_nettype wire
